// File: design/pyc_pkg.sv
// Package: shared constants and types of the PhotoYCC colour twist.
package pyc_pkg;

   localparam int NumChan  = 3;
   localparam int AddrW    = 5;
   localparam int DataW    = 64;
   localparam int RegW     = 48;

   // Register map, index = paddr[4:3]
   localparam logic [1:0] REG_GAINS_LUMA    = 2'd0;
   localparam logic [1:0] REG_GAINS_CHROMA1 = 2'd1;
   localparam logic [1:0] REG_GAINS_CHROMA2 = 2'd2;
   localparam logic [1:0] REG_ROW_OFFSETS   = 2'd3;

   localparam logic [RegW-1:0] GAINS_LUMA_RST    = 48'h0000_0000_1000;
   localparam logic [RegW-1:0] GAINS_CHROMA1_RST = 48'h0000_1000_0000;
   localparam logic [RegW-1:0] GAINS_CHROMA2_RST = 48'h1000_0000_0000;
   localparam logic [RegW-1:0] ROW_OFFSETS_RST   = 48'h0000_0000_0000;

   // Forward scales Q2.16, reciprocal scales Q0.16, channel centres
   localparam logic [17:0] FwdScale [NumChan] = '{18'd89022, 18'd145352, 18'd119374};
   localparam logic [15:0] InvScale [NumChan] = '{16'd48245, 16'd29549, 16'd35979};
   localparam logic [7:0]  Centre   [NumChan] = '{8'd0, 8'd156, 8'd137};

   localparam int NormRnd  = 128;      // half LSB before >> 8
   localparam int SumRnd   = 2048;     // half LSB before >> 12
   localparam int ReconRnd = 131072;   // 1/128 byte guard in Q.24

   localparam int NormMax = 524287;
   localparam int NormMin = -524288;

   typedef logic signed [17:0] norm_type;    // normalised input, Q.8
   typedef logic signed [33:0] prod_type;    // gain * norm, Q.20
   typedef logic signed [19:0] twist_type;   // saturated row result, Q11.8
   typedef logic signed [36:0] recon_type;   // twist * reciprocal, Q.24

endpackage

// File: design/pyc_if.sv
// Interfaces: pixel request and response channels.
interface pyc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_luma;
   logic [7:0] in_chroma_one;
   logic [7:0] in_chroma_two;
   logic       in_last;

   modport source (output valid, in_luma, in_chroma_one, in_chroma_two, in_last,
                   input ready);
   modport sink   (input valid, in_luma, in_chroma_one, in_chroma_two, in_last,
                   output ready);
endinterface

interface pyc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_luma;
   logic [7:0] out_chroma_one;
   logic [7:0] out_chroma_two;
   logic       out_last;

   modport source (output valid, out_luma, out_chroma_one, out_chroma_two, out_last,
                   input ready);
   modport sink   (input valid, out_luma, out_chroma_one, out_chroma_two, out_last,
                   output ready);
endinterface

// File: design/photoycc_color_twist.sv
// Top level: five-stage PhotoYCC colour-twist pipeline with APB register port.
//
// Usage:
//  - req_bus carries one PhotoYCC pixel per transaction (luma, two chroma bytes,
//    a last marker); rsp_bus returns exactly one twisted pixel per transaction,
//    in order, with the last marker copied through.
//  - A request passes through five registered stages on its way to a response:
//    normalise, nine gain products, row sum/round/saturate, reciprocal multiply,
//    re-centre/clamp into the output register.
//  - Throughput is one pixel per clock while rsp_bus.ready stays high; each
//    stage holds one pixel.
//  - A stalled response (rsp_bus.ready low) holds the output register; each
//    stage still fills while it is empty, so up to five pixels are buffered
//    before req_bus.ready drops. Nothing is lost or repeated.
//  - Synchronous reset empties the pipe and loads the identity matrix with
//    zero offsets; pready is always high. The APB port (64-bit data, registers
//    at 8*index) is written by the user only while the pipe is idle (unenforced).
module photoycc_color_twist (
   input  logic                        clock,
   input  logic                        reset,
   pyc_req_if.sink                     req_bus,
   pyc_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pyc_pkg::AddrW-1:0]   paddr,
   input  logic [pyc_pkg::DataW-1:0]   pwdata,
   output logic [pyc_pkg::DataW-1:0]   prdata,
   output logic                        pready
);

   localparam int NC = pyc_pkg::NumChan;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [pyc_pkg::RegW-1:0] gain_ff [NC];
   logic [pyc_pkg::RegW-1:0] offset_ff;
   logic [1:0]               reg_idx;
   logic                     csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= pyc_pkg::GAINS_LUMA_RST;
         gain_ff[1] <= pyc_pkg::GAINS_CHROMA1_RST;
         gain_ff[2] <= pyc_pkg::GAINS_CHROMA2_RST;
         offset_ff  <= pyc_pkg::ROW_OFFSETS_RST;
      end else if (csr_wr) begin
         case (reg_idx)
            pyc_pkg::REG_GAINS_LUMA:    gain_ff[0] <= pwdata[pyc_pkg::RegW-1:0];
            pyc_pkg::REG_GAINS_CHROMA1: gain_ff[1] <= pwdata[pyc_pkg::RegW-1:0];
            pyc_pkg::REG_GAINS_CHROMA2: gain_ff[2] <= pwdata[pyc_pkg::RegW-1:0];
            pyc_pkg::REG_ROW_OFFSETS:   offset_ff  <= pwdata[pyc_pkg::RegW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         pyc_pkg::REG_GAINS_LUMA:    prdata = {16'b0, gain_ff[0]};
         pyc_pkg::REG_GAINS_CHROMA1: prdata = {16'b0, gain_ff[1]};
         pyc_pkg::REG_GAINS_CHROMA2: prdata = {16'b0, gain_ff[2]};
         pyc_pkg::REG_ROW_OFFSETS:   prdata = {16'b0, offset_ff};
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control: a stage takes new data when it is empty or when
   // the stage after it is taking its contents this cycle.
   // ------------------------------------------------------------------
   logic [5:1] vld_ff;
   logic [5:1] vld_in;
   logic [5:1] adv;
   logic [5:1] last_ff;

   assign adv[5] = !vld_ff[5] || rsp_bus.ready;
   assign adv[4] = !vld_ff[4] || adv[5];
   assign adv[3] = !vld_ff[3] || adv[4];
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];

   assign req_bus.ready = adv[1];

   always_comb begin
      vld_in[1] = adv[1] ? req_bus.valid : vld_ff[1];
      for (int k = 2; k <= 5; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         last_ff[1] <= req_bus.in_last;
      end
      for (int k = 2; k <= 5; k++) begin
         if (adv[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: centre the bytes and scale into Q.8 (floor of rounded value)
   // ------------------------------------------------------------------
   logic [7:0]              in_byte [NC];
   logic signed [27:0]      term    [NC];
   logic signed [27:0]      fwd_p   [NC];
   pyc_pkg::norm_type       norm_in [NC];
   pyc_pkg::norm_type       norm_ff [NC];

   assign in_byte[0] = req_bus.in_luma;
   assign in_byte[1] = req_bus.in_chroma_one;
   assign in_byte[2] = req_bus.in_chroma_two;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         term[c]    = $signed({20'b0, in_byte[c]}) - $signed({20'b0, pyc_pkg::Centre[c]});
         fwd_p[c]   = term[c] * $signed({10'b0, pyc_pkg::FwdScale[c]})
                      + 28'(pyc_pkg::NormRnd);
         norm_in[c] = fwd_p[c][25:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         norm_ff <= norm_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: nine Q3.12 x Q.8 products
   // ------------------------------------------------------------------
   pyc_pkg::prod_type  prod_in [NC][NC];
   pyc_pkg::prod_type  prod_ff [NC][NC];
   logic signed [15:0] gain_f  [NC][NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         for (int c = 0; c < NC; c++) begin
            gain_f[r][c]  = gain_ff[r][16*c +: 16];
            prod_in[r][c] = gain_f[r][c] * norm_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         prod_ff <= prod_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: row sum with offset, round half up to Q.8, saturate
   // ------------------------------------------------------------------
   logic signed [35:0]  row_acc [NC];
   logic signed [35:0]  row_sh  [NC];
   pyc_pkg::twist_type  twist_in [NC];
   pyc_pkg::twist_type  twist_ff [NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         row_acc[r] = $signed({{4{offset_ff[16*r+15]}}, offset_ff[16*r +: 16], 16'b0})
                      + 36'(prod_ff[r][0]) + 36'(prod_ff[r][1]) + 36'(prod_ff[r][2])
                      + 36'(pyc_pkg::SumRnd);
         row_sh[r]  = row_acc[r] >>> 12;
         if (row_sh[r] > 36'(pyc_pkg::NormMax)) begin
            twist_in[r] = 20'(pyc_pkg::NormMax);
         end else if (row_sh[r] < 36'(pyc_pkg::NormMin)) begin
            twist_in[r] = 20'(pyc_pkg::NormMin);
         end else begin
            twist_in[r] = row_sh[r][19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         twist_ff <= twist_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: multiply by reciprocal scale into Q.24
   // ------------------------------------------------------------------
   pyc_pkg::recon_type recon_in [NC];
   pyc_pkg::recon_type recon_ff [NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         recon_in[r] = twist_ff[r] * $signed({1'b0, pyc_pkg::InvScale[r]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         recon_ff <= recon_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: add centre and guard, truncate, clamp to a byte
   // ------------------------------------------------------------------
   logic signed [37:0] recon_s  [NC];
   logic [7:0]         byte_in  [NC];
   logic [7:0]         byte_ff  [NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         recon_s[r] = 38'(recon_ff[r]) + $signed({6'b0, pyc_pkg::Centre[r], 24'b0})
                      + 38'(pyc_pkg::ReconRnd);
         if (recon_s[r] <= 38'sd0) begin
            byte_in[r] = 8'd0;
         end else if (recon_s[r][37:32] != 6'd0) begin
            byte_in[r] = 8'd255;
         end else begin
            byte_in[r] = recon_s[r][31:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         byte_ff <= byte_in;
      end
   end

   assign rsp_bus.valid          = vld_ff[5];
   assign rsp_bus.out_luma       = byte_ff[0];
   assign rsp_bus.out_chroma_one = byte_ff[1];
   assign rsp_bus.out_chroma_two = byte_ff[2];
   assign rsp_bus.out_last       = last_ff[5];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   // a receiver that takes the output frees every stage back to the input
   a_ready_chain: assert property (@(posedge clock) rsp_bus.ready |-> req_bus.ready)
      else $error("request stalled while response side ready");

   // a luma-row write lands in the register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[4:3] == pyc_pkg::REG_GAINS_LUMA))
      |=> (gain_ff[0] == $past(pwdata[pyc_pkg::RegW-1:0])))
      else $error("luma gain row write lost");

endmodule

// File: tb/photoycc_color_twist_checker.sv
// Checker: predicts each twisted pixel and compares the response stream against it.
module photoycc_color_twist_checker (
   input  logic                        clock,
   input  logic                        reset,
   pyc_req_if                          req_bus,
   pyc_rsp_if                          rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [pyc_pkg::AddrW-1:0]   paddr,
   input  logic [pyc_pkg::DataW-1:0]   pwdata,
   output int                          fail_count,
   output int                          pending
);

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_one;
      logic [7:0] chroma_two;
      logic       last;
   } ycc_pixel_type;

   // Q2.16 forward scales, Q0.16 reciprocals, channel centres
   localparam longint ScaleFwd [3] = '{89022, 145352, 119374};
   localparam longint ScaleInv [3] = '{48245, 29549, 35979};
   localparam longint Middle   [3] = '{0, 156, 137};

   logic [pyc_pkg::RegW-1:0] gain_row [pyc_pkg::NumChan];
   logic [pyc_pkg::RegW-1:0] offset_row;
   ycc_pixel_type            awaited_pixels [$];

   function automatic longint coef(input logic [pyc_pkg::RegW-1:0] packed_row, input int k);
      return longint'($signed(packed_row[16*k +: 16]));
   endfunction

   function automatic ycc_pixel_type twist_pixel(input logic [7:0] luma, chroma_one,
                                                 chroma_two, input logic last);
      longint        norm [3];
      longint        acc;
      longint        v;
      longint        s;
      logic [7:0]    byte_out [3];
      ycc_pixel_type px;
      norm[0] = (longint'(luma) * ScaleFwd[0] + 128) >>> 8;
      norm[1] = ((longint'(chroma_one) - 156) * ScaleFwd[1] + 128) >>> 8;
      norm[2] = ((longint'(chroma_two) - 137) * ScaleFwd[2] + 128) >>> 8;
      for (int r = 0; r < 3; r++) begin
         acc = coef(offset_row, r) * 65536;
         for (int c = 0; c < 3; c++)
            acc += coef(gain_row[r], c) * norm[c];
         v = (acc + 2048) >>> 12;
         if (v > 524287) v = 524287;
         if (v < -524288) v = -524288;
         s = v * ScaleInv[r] + (Middle[r] <<< 24) + 131072;
         if (s <= 0)
            byte_out[r] = 8'd0;
         else if ((s >>> 24) > 255)
            byte_out[r] = 8'd255;
         else
            byte_out[r] = 8'(s >>> 24);
      end
      px.luma       = byte_out[0];
      px.chroma_one = byte_out[1];
      px.chroma_two = byte_out[2];
      px.last       = last;
      return px;
   endfunction

   task automatic check_field(input string name, input int unsigned want, got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      ycc_pixel_type want;
      if (reset) begin
         gain_row[0] = pyc_pkg::GAINS_LUMA_RST;
         gain_row[1] = pyc_pkg::GAINS_CHROMA1_RST;
         gain_row[2] = pyc_pkg::GAINS_CHROMA2_RST;
         offset_row  = pyc_pkg::ROW_OFFSETS_RST;
         awaited_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[pyc_pkg::AddrW-1:3])
               pyc_pkg::REG_GAINS_LUMA:    gain_row[0] = pwdata[pyc_pkg::RegW-1:0];
               pyc_pkg::REG_GAINS_CHROMA1: gain_row[1] = pwdata[pyc_pkg::RegW-1:0];
               pyc_pkg::REG_GAINS_CHROMA2: gain_row[2] = pwdata[pyc_pkg::RegW-1:0];
               pyc_pkg::REG_ROW_OFFSETS:   offset_row  = pwdata[pyc_pkg::RegW-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            awaited_pixels.insert(awaited_pixels.size(),
                                  twist_pixel(req_bus.in_luma, req_bus.in_chroma_one,
                                              req_bus.in_chroma_two, req_bus.in_last));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_pixels.size() == 0) begin
               $error("response transaction with no pixel outstanding");
               fail_count++;
            end else begin
               want = awaited_pixels.pop_front();
               check_field("out_luma", want.luma, rsp_bus.out_luma);
               check_field("out_chroma_one", want.chroma_one, rsp_bus.out_chroma_one);
               check_field("out_chroma_two", want.chroma_two, rsp_bus.out_chroma_two);
               check_field("out_last", want.last, rsp_bus.out_last);
            end
         end
      end
      pending = awaited_pixels.size();
   end

endmodule

// File: tb/photoycc_color_twist_tb.sv
// Testbench top: stimulus, register programming and verdict for the colour twist.
module photoycc_color_twist_tb;

   // Generous ceiling for ~2100 pixels plus drains
   localparam int CycleLimit   = 200000;
   localparam int RandomPhases = 8;
   localparam int PhaseItems   = 250;

   // Directed pixels {luma, chroma one, chroma two, last}: black, white, neutral
   // centre, chroma extremes and one step either side of the centre
   localparam logic [24:0] EdgePixels [20] = '{
      {8'd0,   8'd0,   8'd0,   1'b0}, {8'd255, 8'd255, 8'd255, 1'b1},
      {8'd0,   8'd156, 8'd137, 1'b0}, {8'd255, 8'd156, 8'd137, 1'b1},
      {8'd128, 8'd0,   8'd255, 1'b0}, {8'd128, 8'd255, 8'd0,   1'b1},
      {8'd1,   8'd157, 8'd138, 1'b0}, {8'd254, 8'd155, 8'd136, 1'b1},
      {8'd0,   8'd255, 8'd0,   1'b0}, {8'd255, 8'd0,   8'd255, 1'b1},
      // saturating matrices
      {8'd255, 8'd255, 8'd255, 1'b0}, {8'd0,   8'd0,   8'd0,   1'b1},
      {8'd0,   8'd156, 8'd137, 1'b0}, {8'd255, 8'd0,   8'd255, 1'b1},
      {8'd255, 8'd255, 8'd255, 1'b1}, {8'd0,   8'd0,   8'd0,   1'b0},
      {8'd0,   8'd156, 8'd137, 1'b1}, {8'd128, 8'd255, 8'd0,   1'b0},
      // zero gains: outputs follow the offsets alone
      {8'd17,  8'd200, 8'd40,  1'b0}, {8'd240, 8'd3,   8'd250, 1'b1}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [pyc_pkg::AddrW-1:0]   paddr;
   logic [pyc_pkg::DataW-1:0]   pwdata;
   logic [pyc_pkg::DataW-1:0]   prdata;
   logic                        pready;

   int fail_count;
   int pending;
   int cycles = 0;
   int stall_left = 0;
   int pixels_sent = 0;
   int settings_applied = 1;

   pyc_req_if req_bus ();
   pyc_rsp_if rsp_bus ();

   always #5 clock = ~clock;

   photoycc_color_twist dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   photoycc_color_twist_checker twist_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $error("timed out after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side back-pressure. Its own pattern, cycling through four in turn:
   // always ready, coin toss, mostly ready, and occasional long stalls.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         case ((cycles / 300) % 4)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  rsp_bus.ready <= 1'b0;
                  stall_left    <= $urandom_range(2, 11);
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // valid is left high so a back-to-back transaction needs no extra edge.
   task automatic push_pixel(input logic [24:0] px);
      req_bus.valid         <= 1'b1;
      req_bus.in_luma       <= px[24:17];
      req_bus.in_chroma_one <= px[16:9];
      req_bus.in_chroma_two <= px[8:1];
      req_bus.in_last       <= px[0];
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Holds the request side off until every pixel sent has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // APB write: setup phase, then access phase until pready
   task automatic write_reg(input logic [1:0] idx, input logic [pyc_pkg::RegW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      // upper bits carry junk; the register keeps only 48
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_matrix(input logic [pyc_pkg::RegW-1:0] luma_row, chroma1_row,
                             chroma2_row, offsets);
      wait_drained();
      write_reg(pyc_pkg::REG_GAINS_LUMA, luma_row);
      write_reg(pyc_pkg::REG_GAINS_CHROMA1, chroma1_row);
      write_reg(pyc_pkg::REG_GAINS_CHROMA2, chroma2_row);
      write_reg(pyc_pkg::REG_ROW_OFFSETS, offsets);
      settings_applied++;
   endtask

   // diag < 0 gives an offsets row; otherwise a gain row near identity on diag.
   // One row in five is fully random, which mostly saturates.
   function automatic logic [pyc_pkg::RegW-1:0] random_row(input int diag);
      logic [pyc_pkg::RegW-1:0] packed_row;
      int                       v;
      if ($urandom_range(0, 4) == 0)
         return {16'($urandom), $urandom};
      for (int k = 0; k < 3; k++) begin
         if (diag < 0)
            v = int'($urandom_range(0, 3200)) - 1600;
         else
            v = int'($urandom_range(0, 12288)) - 6144 + ((k == diag) ? 4096 : 0);
         packed_row[16*k +: 16] = 16'(v);
      end
      return packed_row;
   endfunction

   // Bias towards the byte extremes so clamping is hit often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int  burst_left;
      bit  gapless;
      req_bus.valid         = 1'b0;
      req_bus.in_luma       = 8'd0;
      req_bus.in_chroma_one = 8'd0;
      req_bus.in_chroma_two = 8'd0;
      req_bus.in_last       = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset matrix is identity: pixels should come back unchanged
      for (int i = 0; i < 10; i++) push_pixel(EdgePixels[i]);

      // Largest positive gains and offsets: row sums saturate high
      set_matrix(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                 48'h7FFF_7FFF_7FFF);
      for (int i = 10; i < 14; i++) push_pixel(EdgePixels[i]);

      // Most negative gains and offsets: saturate low, outputs clamp to zero
      set_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                 48'h8000_8000_8000);
      for (int i = 14; i < 18; i++) push_pixel(EdgePixels[i]);

      // No gains at all, random offsets
      set_matrix('0, '0, '0, random_row(-1));
      for (int i = 18; i < 20; i++) push_pixel(EdgePixels[i]);

      // Random matrices with bursty requests; every third phase runs gapless
      for (int phase = 0; phase < RandomPhases; phase++) begin
         set_matrix(random_row(0), random_row(1), random_row(2), random_row(-1));
         gapless    = (phase % 3 == 2);
         burst_left = 0;
         for (int i = 0; i < PhaseItems; i++) begin
            if (phase == 3 && i == PhaseItems / 2)
               wait_drained();
            if (burst_left == 0) begin
               idle(gapless ? 0 : $urandom_range(0, 6));
               burst_left = $urandom_range(1, 24);
            end
            push_pixel({pick_byte(), pick_byte(), pick_byte(), ($urandom_range(0, 15) == 0)});
            burst_left--;
         end
      end

      // Drain, then keep the clock running to catch stray responses
      wait_drained();
      repeat (20) @(negedge clock);

      $display("Sent %0d pixels across %0d matrix settings (identity, saturating, zero, random).",
               pixels_sent, settings_applied);
      $display("Responses were back-pressured by steady, random and long-stall patterns.");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: photoycc_color_twist.f
design/pyc_pkg.sv
design/pyc_if.sv
design/photoycc_color_twist.sv
tb/photoycc_color_twist_checker.sv
tb/photoycc_color_twist_tb.sv
